// ===== hw/rtl/rsh_pkg.sv =====
`timescale 1ns / 1ps

package rsh_pkg;

    // band limits and output format
    localparam int MAX_BAND_LIMIT  = 8;
    localparam int VALUE_FRAC_BITS = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_BAND  = 2'd0;
    localparam logic [1:0] CFG_SYMMETRIC = 2'd1;

    // multiplier rounding shifts
    localparam logic [5:0] MUL_SH_INT = 6'd0;
    localparam logic [5:0] MUL_SH_Q30 = 6'd30;
    localparam logic [5:0] MUL_SH_VAL = 6'(54 - VALUE_FRAC_BITS);

    localparam logic [63:0] INV4PI_Q40 = 64'd87496355274;

    // divide / root unit handshake
    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_du_req;

    typedef struct packed {
        logic        busy;
        logic [39:0] result;
    } t_du_rsp;

    typedef logic [8:0][8:0][31:0] t_ktab;

    // normalization constants K(l,m) in Q30, worked out at elaboration
    function automatic t_ktab build_ktab();
        t_ktab        t;
        logic [63:0]  df;
        logic [63:0]  fa;
        logic [63:0]  fb;
        logic [63:0]  a;
        logic [63:0]  rem;
        logic [63:0]  q;
        logic [63:0]  n;
        logic [63:0]  res;
        logic [63:0]  bitv;
        logic [127:0] prod;
        t = '0;
        for (int l = 0; l <= 8; l++) begin
            for (int m = 0; m <= l; m++) begin
                df = 64'd1;
                for (int i = 1; i <= 2 * m - 1; i += 2) df = df * 64'(i);
                fa = 64'd1;
                for (int i = 2; i <= l - m; i++) fa = fa * 64'(i);
                fb = 64'd1;
                for (int i = 2; i <= l + m; i++) fb = fb * 64'(i);
                a = 64'(2 * l + 1) * ((m != 0) ? 64'd2 : 64'd1) * df * df * fa;
                prod = 128'(INV4PI_Q40) * 128'(a);
                rem = '0;
                q = '0;
                for (int i = 127; i >= 0; i--) begin
                    rem = {rem[62:0], prod[i]};
                    q = {q[62:0], 1'b0};
                    if (rem >= fb) begin
                        rem = rem - fb;
                        q[0] = 1'b1;
                    end
                end
                n = q << 20;
                res = '0;
                bitv = 64'd1 << 62;
                for (int j = 0; j < 32; j++) begin
                    if (n >= res + bitv) begin
                        n = n - (res + bitv);
                        res = (res >> 1) + bitv;
                    end else begin
                        res = res >> 1;
                    end
                    bitv = bitv >> 2;
                end
                t[l][m] = res[31:0];
            end
        end
        return t;
    endfunction

    localparam t_ktab K_TAB = build_ktab();

endpackage

// ===== hw/rtl/rsh_mul.sv =====
`timescale 1ns / 1ps

// signed multiply, magnitude rounded half away from zero, registered result
module rsh_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [35:0] i_b,
    input  logic        [5:0]  i_sh,
    output logic signed [39:0] o_p
);

    logic [31:0] mag_a;
    logic [35:0] mag_b;
    logic [67:0] prod;
    logic [67:0] rnd;
    logic [39:0] mag_p;
    logic        neg;

    always_comb begin
        mag_a = i_a[31] ? 32'(-i_a) : 32'(i_a);
        mag_b = i_b[35] ? 36'(-i_b) : 36'(i_b);
        prod  = 68'(mag_a) * 68'(mag_b);
        if (i_sh == rsh_pkg::MUL_SH_INT) begin
            rnd = prod;
        end else begin
            rnd = (prod + (68'd1 << (i_sh - 6'd1))) >> i_sh;
        end
        mag_p = rnd[39:0];
        neg   = i_a[31] ^ i_b[35];
    end

    always_ff @(posedge i_clk) begin
        o_p <= neg ? -$signed(mag_p) : $signed(mag_p);
    end

endmodule

// ===== hw/rtl/rsh_divsqrt.sv =====
`timescale 1ns / 1ps

// shift-subtract unit: 40-step restoring divide or 32-step integer square root
module rsh_divsqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rsh_pkg::t_du_req i_req,
    input  logic [63:0]      i_num,
    input  logic [31:0]      i_den,
    output rsh_pkg::t_du_rsp o_rsp
);

    logic        r_busy;
    logic        r_sqrt;
    logic [5:0]  r_cnt;
    logic [33:0] r_rem;
    logic [63:0] r_num;
    logic [31:0] r_root;
    logic [31:0] r_den;

    logic [35:0] cand;
    logic [35:0] trial;
    logic [36:0] diff;
    logic        ge;

    always_comb begin
        if (r_sqrt) begin
            cand  = {r_rem, r_num[63:62]};
            trial = {2'b00, r_root, 2'b01};
        end else begin
            cand  = {3'b000, r_rem[31:0], r_num[39]};
            trial = {4'b0000, r_den};
        end
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = !diff[36];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == 6'd1) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.is_sqrt;
            r_root <= '0;
            r_den  <= i_den;
            if (i_req.is_sqrt) begin
                r_cnt <= 6'd32;
                r_rem <= '0;
                r_num <= i_num;
            end else begin
                r_cnt <= 6'd40;
                r_rem <= {12'd0, i_num[61:40]};
                r_num <= {24'd0, i_num[39:0]};
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            r_rem <= ge ? diff[33:0] : cand[33:0];
            if (r_sqrt) begin
                r_root <= {r_root[30:0], ge};
                r_num  <= {r_num[61:0], 2'b00};
            end else begin
                r_num <= {r_num[62:0], ge};
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.result = r_sqrt ? {8'd0, r_root} : r_num[39:0];

endmodule

// ===== hw/rtl/real_sh_basis_row.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_stall   i_dir_x, i_dir_y, i_dir_z
// output    out        o_out_valid / i_out_stall o_basis_value, o_coeff_index,
//                                                o_band, o_order, o_last
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// a direction is normalized first (squared length, square root, three divides;
// a zero vector skips root and divides), then each coefficient takes the power
// (ux + i uy)^|m| and, for l > |m|, the legendre recurrence up to band l
// sync active-low reset clears sequencer, output valid and config registers
// o_in_stall is high from acceptance until the last coefficient is loaded;
// a stalled output only holds the sequencer when the next value is ready

module real_sh_basis_row (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [19:0] o_basis_value,
    output logic        [5:0]  o_coeff_index,
    output logic        [3:0]  o_band,
    output logic signed [4:0]  o_order,
    output logic               o_last,
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_index,
    input  logic        [3:0]  i_cfg_data
);

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_NX   = 5'd1;
    localparam logic [4:0] S_NY   = 5'd2;
    localparam logic [4:0] S_NZ   = 5'd3;
    localparam logic [4:0] S_NS   = 5'd4;
    localparam logic [4:0] S_SQ   = 5'd5;
    localparam logic [4:0] S_SQW  = 5'd6;
    localparam logic [4:0] S_DV   = 5'd7;
    localparam logic [4:0] S_DVW  = 5'd8;
    localparam logic [4:0] S_ROW  = 5'd9;
    localparam logic [4:0] S_C0   = 5'd10;
    localparam logic [4:0] S_C1   = 5'd11;
    localparam logic [4:0] S_C2   = 5'd12;
    localparam logic [4:0] S_C3   = 5'd13;
    localparam logic [4:0] S_C4   = 5'd14;
    localparam logic [4:0] S_LQ   = 5'd15;
    localparam logic [4:0] S_L1   = 5'd16;
    localparam logic [4:0] S_L2   = 5'd17;
    localparam logic [4:0] S_T0   = 5'd18;
    localparam logic [4:0] S_T1   = 5'd19;
    localparam logic [4:0] S_T2   = 5'd20;
    localparam logic [4:0] S_T3   = 5'd21;
    localparam logic [4:0] S_T4   = 5'd22;
    localparam logic [4:0] S_T5   = 5'd23;
    localparam logic [4:0] S_K0   = 5'd24;
    localparam logic [4:0] S_K1   = 5'd25;
    localparam logic [4:0] S_K2   = 5'd26;
    localparam logic [4:0] S_OUT  = 5'd27;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [35:0] ONE_Q24 = 36'sd16777216;

    // config registers
    logic [3:0] r_max_band;
    logic       r_sym;

    logic [4:0] r_state;

    // per-direction working set
    logic signed [15:0] r_x, r_y, r_z;
    logic signed [39:0] r_acc;
    logic        [31:0] r_s;
    logic        [1:0]  r_k;
    logic signed [31:0] r_ux, r_uy, r_uz;
    logic        [3:0]  r_lmax;
    logic        [3:0]  r_l;
    logic signed [4:0]  r_m;
    logic        [5:0]  r_idx;

    // complex power (ux + i uy)^|m|
    logic signed [31:0] r_re, r_im, r_t1, r_tre;
    logic        [3:0]  r_i;

    // legendre recurrence
    logic signed [35:0] r_q0, r_q1;
    logic        [3:0]  r_ll;
    logic signed [39:0] r_t;
    logic signed [39:0] r_v;

    // output register
    logic               r_ovalid;
    logic signed [19:0] r_obv;
    logic        [5:0]  r_oidx;
    logic        [3:0]  r_oband;
    logic signed [4:0]  r_oorder;
    logic               r_olast;

    // shared units
    logic signed [31:0] mul_a;
    logic signed [35:0] mul_b;
    logic        [5:0]  mul_sh;
    logic signed [39:0] mul_p;
    rsh_pkg::t_du_req   du_req;
    rsh_pkg::t_du_rsp   du_rsp;
    logic        [63:0] du_num;
    logic        [31:0] du_den;

    // derived values
    logic        [3:0]  lmax_c;
    logic        [3:0]  am;
    logic        [3:0]  dnum;
    logic signed [15:0] comp_c;
    logic signed [16:0] comp_neg;
    logic        [15:0] comp_mag;
    logic        [39:0] t_mag;
    logic        [31:0] u_mag;
    logic signed [31:0] trig_c;
    logic        [4:0]  lnext;
    logic               is_last;
    logic               out_free;
    logic signed [19:0] sat_v;
    logic               in_acc;

    rsh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .i_sh  (mul_sh),
        .o_p   (mul_p)
    );

    rsh_divsqrt u_du (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (du_req),
        .i_num   (du_num),
        .i_den   (du_den),
        .o_rsp   (du_rsp)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;

    always_comb begin
        // band limit for the row: clamp to limit, full mode to 7, even in symmetric mode
        lmax_c = (r_max_band > 4'(rsh_pkg::MAX_BAND_LIMIT))
               ? 4'(rsh_pkg::MAX_BAND_LIMIT) : r_max_band;
        if (!r_sym && lmax_c > 4'd7) lmax_c = 4'd7;
        if (r_sym) lmax_c[0] = 1'b0;

        am   = r_m[4] ? 4'(-r_m) : r_m[3:0];
        dnum = r_ll - am;

        case (r_k)
            2'd0:    comp_c = r_x;
            2'd1:    comp_c = r_y;
            default: comp_c = r_z;
        endcase
        comp_neg = -{comp_c[15], comp_c};
        comp_mag = comp_c[15] ? comp_neg[15:0] : comp_c;

        t_mag  = r_t[39] ? 40'(-r_t) : 40'(r_t);
        u_mag  = (du_rsp.result > 40'd1073741824) ? 32'd1073741824 : du_rsp.result[31:0];
        trig_c = (r_m <= 5'sd0) ? r_re : r_im;

        lnext   = {1'b0, r_l} + (r_sym ? 5'd2 : 5'd1);
        is_last = (lnext > {1'b0, r_lmax}) && (r_m == $signed({1'b0, r_l}));

        if (r_v > 40'sd524287) begin
            sat_v = 20'sh7FFFF;
        end else if (r_v < -40'sd524288) begin
            sat_v = -20'sh80000;
        end else begin
            sat_v = r_v[19:0];
        end
    end

    // operand routing for the shared multiplier and the divide / root unit
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = rsh_pkg::MUL_SH_INT;
        du_req = '0;
        du_num = '0;
        du_den = r_s;
        unique case (r_state)
            S_NX: begin
                mul_a = 32'(r_x);
                mul_b = 36'(r_x);
            end
            S_NY: begin
                mul_a = 32'(r_y);
                mul_b = 36'(r_y);
            end
            S_NZ: begin
                mul_a = 32'(r_z);
                mul_b = 36'(r_z);
            end
            S_SQ: begin
                du_req.start   = (r_acc[31:0] != 32'd0);
                du_req.is_sqrt = 1'b1;
                du_num         = {r_acc[31:0], 32'd0};
            end
            S_DV: begin
                du_req.start = 1'b1;
                du_num       = {2'b00, comp_mag, 46'd0} + {33'd0, r_s[31:1]};
            end
            S_C0: begin
                mul_a  = r_ux;
                mul_b  = 36'(r_re);
                mul_sh = rsh_pkg::MUL_SH_Q30;
            end
            S_C1: begin
                mul_a  = r_uy;
                mul_b  = 36'(r_im);
                mul_sh = rsh_pkg::MUL_SH_Q30;
            end
            S_C2: begin
                mul_a  = r_uy;
                mul_b  = 36'(r_re);
                mul_sh = rsh_pkg::MUL_SH_Q30;
            end
            S_C3: begin
                mul_a  = r_ux;
                mul_b  = 36'(r_im);
                mul_sh = rsh_pkg::MUL_SH_Q30;
            end
            S_LQ: begin
                mul_a  = r_uz;
                mul_b  = ONE_Q24;
                mul_sh = rsh_pkg::MUL_SH_Q30;
            end
            S_L1: begin
                mul_a = 32'({am, 1'b1});
                mul_b = mul_p[35:0];
            end
            S_T0: begin
                mul_a  = r_uz;
                mul_b  = r_q1;
                mul_sh = rsh_pkg::MUL_SH_Q30;
            end
            S_T1: begin
                mul_a = 32'({r_ll, 1'b0} - 5'd1);
                mul_b = mul_p[35:0];
            end
            S_T2: begin
                mul_a = 32'({1'b0, r_ll} + {1'b0, am} - 5'd1);
                mul_b = r_q0;
            end
            S_T4: begin
                du_req.start = 1'b1;
                du_num       = {24'd0, t_mag + 40'(dnum[3:1])};
                du_den       = {28'd0, dnum};
            end
            S_K0: begin
                mul_a  = $signed(rsh_pkg::K_TAB[r_l][am]);
                mul_b  = r_q1;
                mul_sh = rsh_pkg::MUL_SH_Q30;
            end
            S_K1: begin
                mul_a  = trig_c;
                mul_b  = mul_p[35:0];
                mul_sh = rsh_pkg::MUL_SH_VAL;
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_band <= 4'd8;
            r_sym      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rsh_pkg::CFG_MAX_BAND:  r_max_band <= i_cfg_data;
                rsh_pkg::CFG_SYMMETRIC: r_sym      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_acc) r_state <= S_NX;
                S_NX:   r_state <= S_NY;
                S_NY:   r_state <= S_NZ;
                S_NZ:   r_state <= S_NS;
                S_NS:   r_state <= S_SQ;
                S_SQ:   r_state <= (r_acc[31:0] == 32'd0) ? S_ROW : S_SQW;
                S_SQW:  if (!du_rsp.busy) r_state <= S_DV;
                S_DV:   r_state <= S_DVW;
                S_DVW:  if (!du_rsp.busy) r_state <= (r_k == 2'd2) ? S_ROW : S_DV;
                S_ROW:  r_state <= (am == 4'd0) ? S_LQ : S_C0;
                S_C0:   r_state <= S_C1;
                S_C1:   r_state <= S_C2;
                S_C2:   r_state <= S_C3;
                S_C3:   r_state <= S_C4;
                S_C4:   r_state <= (r_i == 4'd1) ? S_LQ : S_C0;
                S_LQ:   r_state <= (r_l == am) ? S_K0 : S_L1;
                S_L1:   r_state <= S_L2;
                S_L2:   r_state <= ({1'b0, am} + 5'd2 > {1'b0, r_l}) ? S_K0 : S_T0;
                S_T0:   r_state <= S_T1;
                S_T1:   r_state <= S_T2;
                S_T2:   r_state <= S_T3;
                S_T3:   r_state <= S_T4;
                S_T4:   r_state <= S_T5;
                S_T5:   if (!du_rsp.busy) r_state <= (r_ll == r_l) ? S_K0 : S_T0;
                S_K0:   r_state <= S_K1;
                S_K1:   r_state <= S_K2;
                S_K2:   r_state <= S_OUT;
                S_OUT:  if (out_free) r_state <= is_last ? S_IDLE : S_ROW;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_x    <= i_dir_x;
                    r_y    <= i_dir_y;
                    r_z    <= i_dir_z;
                    r_lmax <= lmax_c;
                    r_l    <= '0;
                    r_m    <= '0;
                    r_idx  <= '0;
                end
            end
            S_NY: r_acc <= mul_p;
            S_NZ: r_acc <= r_acc + mul_p;
            S_NS: r_acc <= r_acc + mul_p;
            S_SQ: begin
                // zero vector reads as +z
                r_ux <= '0;
                r_uy <= '0;
                r_uz <= ONE_Q30;
            end
            S_SQW: begin
                r_s <= du_rsp.result[31:0];
                r_k <= '0;
            end
            S_DVW: begin
                if (!du_rsp.busy) begin
                    case (r_k)
                        2'd0:    r_ux <= comp_c[15] ? -$signed(u_mag) : $signed(u_mag);
                        2'd1:    r_uy <= comp_c[15] ? -$signed(u_mag) : $signed(u_mag);
                        default: r_uz <= comp_c[15] ? -$signed(u_mag) : $signed(u_mag);
                    endcase
                    r_k <= r_k + 2'd1;
                end
            end
            S_ROW: begin
                r_re <= ONE_Q30;
                r_im <= '0;
                r_i  <= am;
            end
            S_C1: r_t1  <= mul_p[31:0];
            S_C2: r_tre <= r_t1 - mul_p[31:0];
            S_C3: r_t1  <= mul_p[31:0];
            S_C4: begin
                r_re <= r_tre;
                r_im <= r_t1 + mul_p[31:0];
                r_i  <= r_i - 4'd1;
            end
            S_LQ: r_q1 <= ONE_Q24;
            S_L2: begin
                r_q1 <= mul_p[35:0];
                r_q0 <= ONE_Q24;
                r_ll <= am + 4'd2;
            end
            S_T2: r_acc <= mul_p;
            S_T3: r_t   <= r_acc - mul_p;
            S_T5: begin
                if (!du_rsp.busy) begin
                    r_q0 <= r_q1;
                    r_q1 <= r_t[39] ? -$signed(du_rsp.result[35:0])
                                    : $signed(du_rsp.result[35:0]);
                    r_ll <= r_ll + 4'd1;
                end
            end
            S_K2: r_v <= am[0] ? -mul_p : mul_p;
            S_OUT: begin
                if (out_free) begin
                    r_obv    <= sat_v;
                    r_oidx   <= r_idx;
                    r_oband  <= r_l;
                    r_oorder <= r_m;
                    r_olast  <= is_last;
                    r_idx    <= r_idx + 6'd1;
                    if (r_m != $signed({1'b0, r_l})) begin
                        r_m <= r_m + 5'sd1;
                    end else begin
                        r_l <= lnext[3:0];
                        r_m <= -$signed(lnext);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output valid: set on load, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_basis_value = r_obv;
    assign o_coeff_index = r_oidx;
    assign o_band        = r_oband;
    assign o_order       = r_oorder;
    assign o_last        = r_olast;

endmodule
